### src/dfs_pkg.sv
// shared constants, types and codes for the depth-first topological order block
// no dependencies
package dfs_pkg;

	localparam int MAX_NODES  = 64;
	localparam int MAX_DEGREE = 64;
	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int DEG_W      = $clog2(MAX_DEGREE);
	localparam int CNT_W      = $clog2(MAX_DEGREE + 1);
	localparam int DEPTH_W    = $clog2(MAX_NODES + 1);
	localparam int FRAME_W    = NODE_W + CNT_W;
	localparam int STORE_AW   = NODE_W + DEG_W;

	// field widths fixed by the interface
	localparam int OP_W     = 2;
	localparam int FNODE_W  = 6;
	localparam int NCOUNT_W = 7;
	localparam int STAT_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_RUN   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_DROPPED = 2'd1,
		ST_CYCLE   = 2'd2,
		ST_UNUSED  = 2'd3
	} status_t;

	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic REG_START_NODE = 1'b1;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_ADD   = 8'b0000_0010,
		S_FRAME = 8'b0000_0100,
		S_EVAL  = 8'b0000_1000,
		S_POP   = 8'b0001_0000,
		S_ROOT  = 8'b0010_0000,
		S_CYC   = 8'b0100_0000,
		S_END   = 8'b1000_0000
	} state_t;

endpackage

### src/dfs_ram.sv
// generic single-write, single-read synchronous memory with a registered read port
// no dependencies
module dfs_ram #(
	parameter int Depth = 64,
	parameter int Width = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/dfs_topological_order.sv
// top level of the depth-first topological order block: walk sequencer and memories
// depends on dfs_pkg and dfs_ram
//
// Edges are loaded one per item into per-node successor lists held in a
// synchronous memory; a run item walks the graph depth-first from start_node,
// then from every still unvisited node in index order, and returns one result
// per node in finish order (later roots flagged), or a cycle error after the
// nodes finished so far. An add-edge item reads the successor count, then
// writes the list entry; clear and the unused code go straight to a result.
// A run steps each frame by reading its count and list entry, then evaluating
// it; each finished node takes a last look at its exhausted list, each pop
// reloads the parent frame from the stack memory, and the root scan visits
// each index in turn and then closes. Results leave through a one-entry
// output register, so the sequencer only waits when that register is full
// and stalled. Successor counts carry a valid bit per node, so reset and
// clear need not rewrite the count memory.
module dfs_topological_order (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [dfs_pkg::NCOUNT_W-1:0]         cfg_data,
	// input items
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [dfs_pkg::OP_W-1:0]             operation,
	input  logic [dfs_pkg::FNODE_W-1:0]          from_node,
	input  logic [dfs_pkg::FNODE_W-1:0]          to_node,
	// result items
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [dfs_pkg::STAT_W-1:0]           status,
	output logic                                 has_node,
	output logic [dfs_pkg::FNODE_W-1:0]          finished_node,
	output logic                                 later_root,
	output logic                                 last
);
	import dfs_pkg::*;

	state_t state_q;

	// configuration registers
	logic [NCOUNT_W-1:0] node_count_q;
	logic [NODE_W-1:0]   start_node_q;
	logic [DEPTH_W-1:0]  eff_cnt;

	// registered edge operands
	logic [NODE_W-1:0] from_q, to_q;

	// walk state
	logic [MAX_NODES-1:0] visited_q, on_path_q, cnt_vld_q;
	logic [NODE_W-1:0]    top_node_q;
	logic [CNT_W-1:0]     top_next_q;
	logic [DEPTH_W-1:0]   depth_q, scan_q;
	logic                 later_q;

	// one finished node held back so that the final one can carry last
	logic              pend_v_q;
	logic [NODE_W-1:0] pend_node_q;
	logic              pend_root_q;

	// output register
	logic                result_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic                has_node_q, later_root_q, last_q;
	logic [NODE_W-1:0]   fin_node_q;

	// memory ports
	logic                cnt_re, cnt_we, st_re, st_we, stk_re, stk_we;
	logic [NODE_W-1:0]   cnt_raddr;
	logic [CNT_W-1:0]    cnt_rd, cnt_wdata, cnt_cur;
	logic                cnt_vld_s1;
	logic [STORE_AW-1:0] st_raddr, st_waddr;
	logic [NODE_W-1:0]   st_rd;
	logic [NODE_W-1:0]   stk_waddr, stk_raddr;
	logic [FRAME_W-1:0]  stk_rd, stk_wdata;

	logic item_acc, can_emit, drop;
	logic has_more, stale, push, cyc_hit, pop_go;
	logic [DEPTH_W-1:0] depth_dec;

	assign cfg_ready    = 1'b1;
	assign item_acc     = item_valid && !item_stall;
	assign can_emit     = !result_valid_q || !result_stall;
	assign item_stall   = (state_q != S_IDLE) || !can_emit;

	assign result_valid  = result_valid_q;
	assign status        = status_q;
	assign has_node      = has_node_q;
	assign finished_node = fin_node_q;
	assign later_root    = later_root_q;
	assign last          = last_q;

	// zero acts as one node, anything above the capacity as full capacity
	always_comb begin
		if (node_count_q == '0) begin
			eff_cnt = DEPTH_W'(1);
		end else if (DEPTH_W'(node_count_q) > DEPTH_W'(MAX_NODES)) begin
			eff_cnt = DEPTH_W'(MAX_NODES);
		end else begin
			eff_cnt = DEPTH_W'(node_count_q);
		end
	end

	// count entry not written since reset or clear reads as zero
	assign cnt_cur = cnt_vld_s1 ? cnt_rd : '0;

	// add-edge decision
	assign drop = (DEPTH_W'(from_q) >= eff_cnt) || (DEPTH_W'(to_q) >= eff_cnt) ||
		(cnt_cur >= CNT_W'(MAX_DEGREE));

	// walk step decision for the top frame
	assign has_more  = top_next_q < cnt_cur;
	assign stale     = DEPTH_W'(st_rd) >= eff_cnt;
	assign cyc_hit   = has_more && !stale && (on_path_q[st_rd] ||
		(!visited_q[st_rd] && depth_q >= DEPTH_W'(MAX_NODES)));
	assign push      = (state_q == S_EVAL) && has_more && !stale && !on_path_q[st_rd] &&
		!visited_q[st_rd] && depth_q < DEPTH_W'(MAX_NODES);
	assign pop_go    = (state_q == S_EVAL) && !has_more && (!pend_v_q || can_emit);
	assign depth_dec = depth_q - DEPTH_W'(1);

	// memory controls
	always_comb begin
		cnt_re    = (state_q == S_IDLE && item_acc) || state_q == S_FRAME;
		cnt_raddr = (state_q == S_FRAME) ? top_node_q : from_node;
		cnt_we    = (state_q == S_ADD) && can_emit && !drop;
		cnt_wdata = cnt_cur + CNT_W'(1);
		st_re     = state_q == S_FRAME;
		st_raddr  = {top_node_q, top_next_q[DEG_W-1:0]};
		st_we     = cnt_we;
		st_waddr  = {from_q, cnt_cur[DEG_W-1:0]};
		stk_we    = push;
		stk_waddr = depth_dec[NODE_W-1:0];
		stk_wdata = {top_node_q, top_next_q + CNT_W'(1)};
		stk_re    = pop_go && depth_q > DEPTH_W'(1);
		stk_raddr = NODE_W'(depth_q - DEPTH_W'(2));
	end

	dfs_ram #(.Depth(MAX_NODES), .Width(CNT_W)) u_count_ram (
		.clk(clk), .we(cnt_we), .waddr(from_q), .wdata(cnt_wdata),
		.re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rd)
	);

	dfs_ram #(.Depth(MAX_NODES * MAX_DEGREE), .Width(NODE_W)) u_succ_ram (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(to_q),
		.re(st_re), .raddr(st_raddr), .rdata(st_rd)
	);

	dfs_ram #(.Depth(MAX_NODES), .Width(FRAME_W)) u_stack_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.re(stk_re), .raddr(stk_raddr), .rdata(stk_rd)
	);

	// valid bit of the count entry travels with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_s1 <= 1'b0;
		end else if (cnt_re) begin
			cnt_vld_s1 <= cnt_vld_q[cnt_raddr];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NCOUNT_W'(MAX_NODES);
			start_node_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NODE_COUNT: node_count_q <= cfg_data;
				REG_START_NODE: start_node_q <= cfg_data[NODE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			visited_q      <= '0;
			on_path_q      <= '0;
			cnt_vld_q      <= '0;
			depth_q        <= '0;
			scan_q         <= '0;
			later_q        <= 1'b0;
			pend_v_q       <= 1'b0;
			result_valid_q <= 1'b0;
			from_q         <= '0;
			to_q           <= '0;
			top_node_q     <= '0;
			top_next_q     <= '0;
			pend_node_q    <= '0;
			pend_root_q    <= 1'b0;
			status_q       <= ST_OK;
			has_node_q     <= 1'b0;
			fin_node_q     <= '0;
			later_root_q   <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						case (op_t'(operation))
							OP_ADD: begin
								from_q  <= from_node;
								to_q    <= to_node;
								state_q <= S_ADD;
							end
							OP_RUN: begin
								pend_v_q <= 1'b0;
								scan_q   <= '0;
								later_q  <= 1'b0;
								if (DEPTH_W'(start_node_q) < eff_cnt) begin
									visited_q  <= MAX_NODES'(1) << start_node_q;
									on_path_q  <= MAX_NODES'(1) << start_node_q;
									top_node_q <= start_node_q;
									top_next_q <= '0;
									depth_q    <= DEPTH_W'(1);
									state_q    <= S_FRAME;
								end else begin
									visited_q <= '0;
									on_path_q <= '0;
									depth_q   <= '0;
									state_q   <= S_ROOT;
								end
							end
							default: begin
								if (op_t'(operation) == OP_CLEAR) begin
									cnt_vld_q <= '0;
								end
								result_valid_q <= 1'b1;
								status_q       <= ST_OK;
								has_node_q     <= 1'b0;
								fin_node_q     <= '0;
								later_root_q   <= 1'b0;
								last_q         <= 1'b1;
							end
						endcase
					end
				end
				S_ADD: begin
					if (can_emit) begin
						if (!drop) begin
							cnt_vld_q[from_q] <= 1'b1;
						end
						result_valid_q <= 1'b1;
						status_q       <= drop ? ST_DROPPED : ST_OK;
						has_node_q     <= 1'b0;
						fin_node_q     <= '0;
						later_root_q   <= 1'b0;
						last_q         <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				S_FRAME: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (has_more) begin
						top_next_q <= top_next_q + CNT_W'(1);
						if (cyc_hit) begin
							state_q <= S_CYC;
						end else if (push) begin
							visited_q[st_rd] <= 1'b1;
							on_path_q[st_rd] <= 1'b1;
							top_node_q       <= st_rd;
							top_next_q       <= '0;
							depth_q          <= depth_q + DEPTH_W'(1);
							state_q          <= S_FRAME;
						end else begin
							state_q <= S_FRAME;
						end
					end else if (pop_go) begin
						if (pend_v_q) begin
							result_valid_q <= 1'b1;
							status_q       <= ST_OK;
							has_node_q     <= 1'b1;
							fin_node_q     <= pend_node_q;
							later_root_q   <= pend_root_q;
							last_q         <= 1'b0;
						end
						pend_v_q              <= 1'b1;
						pend_node_q           <= top_node_q;
						pend_root_q           <= later_q && depth_dec == '0;
						on_path_q[top_node_q] <= 1'b0;
						depth_q               <= depth_dec;
						state_q               <= (depth_q > DEPTH_W'(1)) ? S_POP : S_ROOT;
					end
				end
				S_POP: begin
					top_node_q <= stk_rd[FRAME_W-1:CNT_W];
					top_next_q <= stk_rd[CNT_W-1:0];
					state_q    <= S_FRAME;
				end
				S_ROOT: begin
					if (scan_q >= eff_cnt) begin
						state_q <= S_END;
					end else begin
						scan_q <= scan_q + DEPTH_W'(1);
						if (!visited_q[scan_q[NODE_W-1:0]]) begin
							visited_q[scan_q[NODE_W-1:0]] <= 1'b1;
							on_path_q[scan_q[NODE_W-1:0]] <= 1'b1;
							top_node_q <= scan_q[NODE_W-1:0];
							top_next_q <= '0;
							depth_q    <= DEPTH_W'(1);
							later_q    <= 1'b1;
							state_q    <= S_FRAME;
						end
					end
				end
				S_CYC: begin
					// flush the held node, then the error result
					if (can_emit) begin
						result_valid_q <= 1'b1;
						if (pend_v_q) begin
							pend_v_q     <= 1'b0;
							status_q     <= ST_OK;
							has_node_q   <= 1'b1;
							fin_node_q   <= pend_node_q;
							later_root_q <= pend_root_q;
							last_q       <= 1'b0;
						end else begin
							status_q     <= ST_CYCLE;
							has_node_q   <= 1'b0;
							fin_node_q   <= '0;
							later_root_q <= 1'b0;
							last_q       <= 1'b1;
							depth_q      <= '0;
							state_q      <= S_IDLE;
						end
					end
				end
				S_END: begin
					if (can_emit) begin
						result_valid_q <= pend_v_q;
						pend_v_q       <= 1'b0;
						status_q       <= ST_OK;
						has_node_q     <= 1'b1;
						fin_node_q     <= pend_node_q;
						later_root_q   <= pend_root_q;
						last_q         <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// stack never grows past the node capacity
	assert property (@(posedge clk) disable iff (!arst_n) depth_q <= DEPTH_W'(MAX_NODES))
		else $error("walk stack overflow");

	// a node on the current path is always marked visited
	assert property (@(posedge clk) disable iff (!arst_n) (on_path_q & ~visited_q) == '0)
		else $error("on-path node not visited");

	// an accepted edge item is decided in the following cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && operation == OP_ADD |=> state_q == S_ADD)
		else $error("edge item not taken to add state");

	// a pending result is never overwritten while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_stall |=> result_valid_q && $stable(fin_node_q))
		else $error("stalled result lost");

endmodule
